// ===== hdl/huffman_tree_build_encode_decode_core_assert.svh =====
// Assertion macros shared by the Huffman tree core.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef HUFFMAN_TREE_BUILD_ENCODE_DECODE_CORE_ASSERT_SVH
`define HUFFMAN_TREE_BUILD_ENCODE_DECODE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hte assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hte assertion failed");

`endif

// ===== hdl/hte_pkg.sv =====
// Shared types and codes for the Huffman tree core.
// No dependencies.
package hte_pkg;

	localparam int CODE_BITS = 31;
	localparam int LEN_W     = 5;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_QUERY  = 2'd1;
	localparam logic [1:0] REQ_DECODE = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NO_TREE   = 2'd1;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_WR_A,
		S_WR_B,
		S_WR_K,
		S_QRY_WAIT,
		S_QRY_UP,
		S_DEC_WAIT,
		S_DEC_SYM
	} hte_state_t;

endpackage

// ===== hdl/hte_node_ram.sv =====
// Node table memory: one write port, one registered read port.
// No dependencies.
module hte_node_ram #(
	parameter int DEPTH = 63,
	parameter int AW    = 6,
	parameter int DW    = 48
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/hte_min2.sv =====
// Tracks the two lightest parentless nodes over one in-order table scan.
// No dependencies.
module hte_min2 #(
	parameter int IW = 6,
	parameter int WW = 21,
	parameter int EW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          in_valid,
	input  logic          in_skip,
	input  logic [IW-1:0] in_idx,
	input  logic [WW-1:0] in_w,
	input  logic [EW-1:0] in_entry,
	output logic [IW-1:0] idx1,
	output logic [IW-1:0] idx2,
	output logic [WW-1:0] w1,
	output logic [WW-1:0] w2,
	output logic [EW-1:0] e1,
	output logic [EW-1:0] e2
);

	logic found1_q, found2_q;
	logic [IW-1:0] idx1_q, idx2_q;
	logic [WW-1:0] w1_q, w2_q;
	logic [EW-1:0] e1_q, e2_q;

	// Strict compares keep the lowest index among equal weights.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found1_q <= 1'b0;
			found2_q <= 1'b0;
		end else if (clear) begin
			found1_q <= 1'b0;
			found2_q <= 1'b0;
		end else if (in_valid && !in_skip) begin
			if (!found1_q || in_w < w1_q) begin
				found1_q <= 1'b1;
				found2_q <= found1_q;
			end else if (!found2_q || in_w < w2_q) begin
				found2_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && in_valid && !in_skip) begin
			if (!found1_q || in_w < w1_q) begin
				idx2_q <= idx1_q;
				w2_q   <= w1_q;
				e2_q   <= e1_q;
				idx1_q <= in_idx;
				w1_q   <= in_w;
				e1_q   <= in_entry;
			end else if (!found2_q || in_w < w2_q) begin
				idx2_q <= in_idx;
				w2_q   <= in_w;
				e2_q   <= in_entry;
			end
		end
	end

	assign idx1 = idx1_q;
	assign idx2 = idx2_q;
	assign w1   = w1_q;
	assign w2   = w2_q;
	assign e1   = e1_q;
	assign e2   = e2_q;

endmodule

// ===== hdl/huffman_tree_build_encode_decode_core.sv =====
// Loads: result in the next cycle. Build after the last leaf: a table scan and three writes per merge.
// Code query: one table read per tree level. Decode bit: one node read, plus a leaf read on reaching a leaf.
// One item at a time; throughput is set by the single read port of the node table.
// Results are single-cycle strobes on done; the receiver cannot stall them.
// Reset clears the control state (leaf count, tree flag, decode position); the node table
// is not cleared and every entry is written before it is read.
`include "huffman_tree_build_encode_decode_core_assert.svh"

module huffman_tree_build_encode_decode_core
	import hte_pkg::*;
#(
	parameter int MAX_LEAVES  = 32,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [7:0]           leaf_symbol,
	input  logic [15:0]          leaf_weight,
	input  logic                 is_last_leaf,
	input  logic [4:0]           leaf_index,
	input  logic                 code_bit,
	output logic                 done,
	output logic [1:0]           status,
	output logic [CODE_BITS-1:0] code_bits,
	output logic [LEN_W-1:0]     code_length,
	output logic [7:0]           symbol,
	output logic                 symbol_valid
);

	localparam int NC  = 2 * MAX_LEAVES - 1;
	localparam int IW  = $clog2(NC);
	localparam int LCW = $clog2(MAX_LEAVES + 1);
	localparam int NWW = WEIGHT_BITS + $clog2(MAX_LEAVES);
	localparam int LW  = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
	localparam int CW  = (LCW > 5) ? LCW : 5;

	typedef struct packed {
		logic [7:0]     sym;
		logic [NWW-1:0] w;
		logic [IW-1:0]  par;
		logic           hp;
		logic [IW-1:0]  lft;
		logic [IW-1:0]  rgt;
	} node_t;

	localparam int EW = $bits(node_t);

	hte_state_t state_q, state_d;
	logic [LCW-1:0] lc_q, lc_d;
	logic built_q, built_d;
	logic [IW-1:0] dp_q, dp_d, k_q, k_d, a_q, a_d, p_q, p_d, up_q, up_d;
	logic code_bit_q, code_bit_d;
	logic done_q, done_d;
	logic [1:0] status_q, status_d;
	logic [CODE_BITS-1:0] bits_q, bits_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0] sym_q, sym_d;
	logic sv_q, sv_d;
	logic rv_s1;
	logic [IW-1:0] ridx_s1;

	logic rd_en, wr_en, trk_clear;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] rd_data, wr_data;
	node_t rd_node, wr_node;

	logic [IW-1:0] t_idx1, t_idx2;
	logic [NWW-1:0] t_w1, t_w2;
	logic [EW-1:0] t_e1, t_e2;

	logic accept, full;
	logic [LCW-1:0] lc_eff, new_lc;
	logic [IW-1:0] root, p_sel, child;
	node_t ea, eb;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign rd_node = node_t'(rd_data);
	assign wr_data = EW'(wr_node);
	assign root    = IW'({lc_q, 1'b0}) - IW'(2);
	assign lc_eff  = built_q ? '0 : lc_q;
	assign full    = (lc_eff >= LCW'(MAX_LEAVES));
	assign new_lc  = lc_eff + LCW'(!full);

	hte_node_ram #(.DEPTH(NC), .AW(IW), .DW(EW)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	hte_min2 #(.IW(IW), .WW(NWW), .EW(EW)) u_min2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (trk_clear),
		.in_valid (rv_s1),
		.in_skip  (rd_node.hp),
		.in_idx   (ridx_s1),
		.in_w     (rd_node.w),
		.in_entry (rd_data),
		.idx1     (t_idx1),
		.idx2     (t_idx2),
		.w1       (t_w1),
		.w2       (t_w2),
		.e1       (t_e1),
		.e2       (t_e2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lc_q       <= '0;
			built_q    <= 1'b0;
			dp_q       <= '0;
			done_q     <= 1'b0;
			rv_s1      <= 1'b0;
		end else begin
			state_q    <= state_d;
			lc_q       <= lc_d;
			built_q    <= built_d;
			dp_q       <= dp_d;
			done_q     <= done_d;
			rv_s1      <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		k_q        <= k_d;
		a_q        <= a_d;
		p_q        <= p_d;
		up_q       <= up_d;
		code_bit_q <= code_bit_d;
		status_q   <= status_d;
		bits_q     <= bits_d;
		len_q      <= len_d;
		sym_q      <= sym_d;
		sv_q       <= sv_d;
		ridx_s1    <= a_q;
	end

	always_comb begin
		state_d    = state_q;
		lc_d       = lc_q;
		built_d    = built_q;
		dp_d       = dp_q;
		k_d        = k_q;
		a_d        = a_q;
		p_d        = p_q;
		up_d       = up_q;
		code_bit_d = code_bit_q;
		status_d   = status_q;
		bits_d     = bits_q;
		len_d      = len_q;
		sym_d      = sym_q;
		sv_d       = sv_q;
		done_d     = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_node    = '0;
		trk_clear  = 1'b0;
		p_sel      = dp_q;
		child      = '0;
		ea         = node_t'(t_e1);
		eb         = node_t'(t_e2);
		ea.hp      = 1'b1;
		ea.par     = k_q;
		eb.hp      = 1'b1;
		eb.par     = k_q;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d   = STAT_OK;
					bits_d     = '0;
					len_d      = '0;
					sym_d      = '0;
					sv_d       = 1'b0;
					code_bit_d = code_bit;
					unique case (req_type)
						REQ_LOAD: begin
							lc_d    = new_lc;
							built_d = 1'b0;
							if (built_q) begin
								dp_d = '0;
							end
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = IW'(lc_eff);
								wr_node.sym = leaf_symbol;
								wr_node.w   = NWW'(leaf_weight[LW-1:0]);
							end
							if (is_last_leaf && new_lc > LCW'(1)) begin
								k_d     = IW'(new_lc);
								a_d     = '0;
								state_d = S_SCAN;
							end else begin
								// A single leaf is a complete tree with its root at node zero.
								if (is_last_leaf && new_lc == LCW'(1)) begin
									built_d = 1'b1;
									dp_d    = '0;
								end
								done_d = 1'b1;
							end
						end
						REQ_QUERY: begin
							if (!built_q) begin
								status_d = STAT_NO_TREE;
								done_d   = 1'b1;
							end else if (CW'(leaf_index) >= CW'(lc_q)) begin
								status_d = STAT_BAD_INDEX;
								done_d   = 1'b1;
							end else begin
								rd_en   = 1'b1;
								rd_addr = IW'(leaf_index);
								p_d     = IW'(leaf_index);
								state_d = S_QRY_WAIT;
							end
						end
						REQ_DECODE: begin
							if (!built_q || lc_q < LCW'(2)) begin
								status_d = STAT_NO_TREE;
								done_d   = 1'b1;
							end else begin
								if ({1'b0, dp_q} >= (IW + 1)'(NC) || dp_q < IW'(lc_q)) begin
									p_sel = root;
								end
								rd_en   = 1'b1;
								rd_addr = p_sel;
								p_d     = p_sel;
								state_d = S_DEC_WAIT;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				rd_en     = 1'b1;
				rd_addr   = a_q;
				a_d       = a_q + IW'(1);
				trk_clear = (a_q == '0);
				if (a_q == k_q - IW'(1)) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = S_WR_A;
			end
			S_WR_A: begin
				wr_en   = 1'b1;
				wr_addr = t_idx1;
				wr_node = ea;
				state_d = S_WR_B;
			end
			S_WR_B: begin
				wr_en   = 1'b1;
				wr_addr = t_idx2;
				wr_node = eb;
				state_d = S_WR_K;
			end
			S_WR_K: begin
				wr_en       = 1'b1;
				wr_addr     = k_q;
				wr_node.w   = t_w1 + t_w2;
				wr_node.lft = t_idx1;
				wr_node.rgt = t_idx2;
				if (k_q == root) begin
					built_d = 1'b1;
					dp_d    = root;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					k_d     = k_q + IW'(1);
					a_d     = '0;
					state_d = S_SCAN;
				end
			end
			S_QRY_WAIT, S_QRY_UP: begin
				// In the upward step the entry read is the parent of p_q.
				if (state_q == S_QRY_UP) begin
					if (len_q < LEN_W'(CODE_BITS)) begin
						if (rd_node.lft != p_q) begin
							bits_d = bits_q | (CODE_BITS'(1) << len_q);
						end
						len_d = len_q + LEN_W'(1);
					end
					p_d = up_q;
				end
				if (rd_node.hp && {1'b0, rd_node.par} < (IW + 1)'(NC)) begin
					rd_en   = 1'b1;
					rd_addr = rd_node.par;
					up_d    = rd_node.par;
					state_d = S_QRY_UP;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DEC_WAIT: begin
				child = code_bit_q ? rd_node.rgt : rd_node.lft;
				if ({1'b0, child} >= (IW + 1)'(NC)) begin
					child = root;
				end
				if (child < IW'(lc_q)) begin
					rd_en   = 1'b1;
					rd_addr = child;
					state_d = S_DEC_SYM;
				end else begin
					dp_d    = child;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DEC_SYM: begin
				sym_d   = rd_node.sym;
				sv_d    = 1'b1;
				dp_d    = root;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign done         = done_q;
	assign status       = status_q;
	assign code_bits    = bits_q;
	assign code_length  = len_q;
	assign symbol       = sym_q;
	assign symbol_valid = sv_q;

	`HTE_ASSERT_SAME(a_done_idle, done_q, !busy)
	`HTE_ASSERT_NEXT(a_accept_progress, accept, busy || done_q)
	`HTE_ASSERT_SAME(a_wr_in_range, wr_en, {1'b0, wr_addr} < (IW + 1)'(NC))
	`HTE_ASSERT_SAME(a_sym_ok, done_q && sv_q, status_q == STAT_OK)
	`HTE_ASSERT_SAME(a_lc_bound, 1'b1, lc_q <= LCW'(MAX_LEAVES))

endmodule
